// ===== hdl/imu_cf_pkg.sv =====
// Shared constants, types and helper functions for the IMU complementary filter.
package imu_cf_pkg;

    localparam int CORDIC_STEPS = 20;

    localparam int IN_W      = 16;
    localparam int ANG_W     = 32;
    localparam int XY_W      = 34;
    localparam int Z_W       = 26;
    localparam int PROD_W    = 50;
    localparam int IDX_W     = 5;
    localparam int MAG_W     = 18;
    localparam int GAIN_W    = 16;
    localparam int WGT_W     = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [IDX_W-1:0] CORDIC_LAST = IDX_W'(CORDIC_STEPS - 1);

    localparam logic [CFG_ADDR_W-1:0] REG_MAG_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAG_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT   = 2'd3;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic signed [Z_W-1:0] Z_NINETY = Z_W'(90 * 65536);

    typedef struct packed {
        logic                   start;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] x;
    } cordic_req_t;

    typedef struct packed {
        logic busy;
        logic valid;
    } cordic_stat_t;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:  r = 26'sd2949120;
            5'd1:  r = 26'sd1740967;
            5'd2:  r = 26'sd919879;
            5'd3:  r = 26'sd466945;
            5'd4:  r = 26'sd234379;
            5'd5:  r = 26'sd117304;
            5'd6:  r = 26'sd58666;
            5'd7:  r = 26'sd29335;
            5'd8:  r = 26'sd14668;
            5'd9:  r = 26'sd7334;
            5'd10: r = 26'sd3667;
            5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;
            5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;
            5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;
            5'd17: r = 26'sd29;
            5'd18: r = 26'sd14;
            5'd19: r = 26'sd7;
            5'd20: r = 26'sd4;
            5'd21: r = 26'sd2;
            5'd22: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [XY_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v[XY_W-1:ANG_W-1] == '0 || v[XY_W-1:ANG_W-1] == '1) begin
            r = v[ANG_W-1:0];
        end else if (v[XY_W-1]) begin
            r = {1'b1, {(ANG_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ANG_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [IN_W:0] abs16(input logic signed [IN_W-1:0] v);
        logic [IN_W:0] e;
        e = {v[IN_W-1], v};
        return v[IN_W-1] ? (~e + 17'd1) : e;
    endfunction

endpackage

// ===== hdl/imu_cf_mul.sv =====
// Shared signed-by-unsigned multiplier with registered product.
module imu_cf_mul (
    input  logic                                     aclk,
    input  logic signed [imu_cf_pkg::ANG_W-1:0]      a,
    input  logic        [imu_cf_pkg::WGT_W-1:0]      b,
    output logic signed [imu_cf_pkg::PROD_W-1:0]     prod
);

    logic signed [imu_cf_pkg::WGT_W:0]    b_s;
    logic signed [imu_cf_pkg::PROD_W-1:0] prod_reg;
    logic signed [imu_cf_pkg::PROD_W-1:0] prod_next;

    assign b_s = {1'b0, b};

    always_comb begin
        prod_next = a * b_s;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/imu_cf_cordic.sv =====
// Iterative CORDIC vectoring unit: atan2(y, x) in Q16.16 degrees, one step per cycle.
module imu_cf_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  imu_cf_pkg::cordic_req_t              req,
    output imu_cf_pkg::cordic_stat_t             stat,
    output logic signed [imu_cf_pkg::Z_W-1:0]    angle
);

    localparam int XW = imu_cf_pkg::XY_W;
    localparam int ZW = imu_cf_pkg::Z_W;

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [imu_cf_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic zero_reg, zero_next;
    logic busy_reg, busy_next;
    logic valid_reg, valid_next;

    logic signed [XW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] at;

    // inputs scaled by 2^14
    assign xs = {{(XW-30){req.x[15]}}, req.x, 14'd0};
    assign ys = {{(XW-30){req.y[15]}}, req.y, 14'd0};
    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = imu_cf_pkg::atan_deg(cnt_reg);

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        if (req.start) begin
            zero_next  = (req.x == '0) && (req.y == '0);
            cnt_next   = '0;
            busy_next  = 1'b1;
            valid_next = 1'b0;
            if (req.x[15]) begin
                if (!req.y[15]) begin
                    x_next = ys;
                    y_next = -xs;
                    z_next = imu_cf_pkg::Z_NINETY;
                end else begin
                    x_next = -ys;
                    y_next = xs;
                    z_next = -imu_cf_pkg::Z_NINETY;
                end
            end else begin
                x_next = xs;
                y_next = ys;
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (!y_reg[XW-1]) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            if (cnt_reg == imu_cf_pkg::CORDIC_LAST) begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;
    assign angle      = zero_reg ? '0 : z_reg;

endmodule

// ===== hdl/imu_complementary_filter.sv =====
// Top level: pitch/roll complementary filter with shared CORDIC and multiplier.
//
// Each input beat carries accel X/Y/Z and gyro X/Y; each output beat carries the
// updated pitch and roll (Q16.16 degrees, saturated) and a flag telling whether the
// accelerometer correction was applied. s_tready is high only while no sample is
// being processed. A sample whose accel magnitude is outside the trusted window
// goes from the gyro update straight to the output state; a trusted sample is paced
// by the two atan2 runs on the single iterative CORDIC unit; the blend multiplies
// share one 32x18 multiplier and overlap the second CORDIC run. A finished result
// waits in the output register while the next sample is accepted.
module imu_complementary_filter (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y
    input  logic [79:0]                             s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // pitch_out, roll_out
    output logic [63:0]                             m_tdata,
    // accel_trusted
    output logic                                    m_tuser,
    input  logic                                    cfg_wr_en,
    input  logic [imu_cf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [imu_cf_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

    localparam int AW = imu_cf_pkg::ANG_W;
    localparam int PW = imu_cf_pkg::PROD_W;
    localparam int XW = imu_cf_pkg::XY_W;
    localparam int ZW = imu_cf_pkg::Z_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_G1   = 4'd1;
    localparam logic [3:0] ST_G2   = 4'd2;
    localparam logic [3:0] ST_G3   = 4'd3;
    localparam logic [3:0] ST_WP   = 4'd4;
    localparam logic [3:0] ST_B1   = 4'd5;
    localparam logic [3:0] ST_B2   = 4'd6;
    localparam logic [3:0] ST_B3   = 4'd7;
    localparam logic [3:0] ST_WR   = 4'd8;
    localparam logic [3:0] ST_C1   = 4'd9;
    localparam logic [3:0] ST_C2   = 4'd10;
    localparam logic [3:0] ST_C3   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic signed [15:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [15:0] gx_reg, gx_next, gy_reg, gy_next;
    logic trusted_reg, trusted_next;
    logic signed [AW-1:0] pitch_reg, pitch_next, roll_reg, roll_next;
    logic signed [ZW-1:0] accp_reg, accp_next;
    logic signed [PW-1:0] sum_reg, sum_next;
    logic [16:0] mag_low_reg, mag_low_next, mag_high_reg, mag_high_next;
    logic [15:0] gain_reg, gain_next;
    logic [16:0] weight_reg, weight_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic signed [AW-1:0] out_pitch_reg, out_pitch_next, out_roll_reg, out_roll_next;
    logic out_trusted_reg, out_trusted_next;

    imu_cf_pkg::cordic_req_t  cord_req;
    imu_cf_pkg::cordic_stat_t cord_stat;
    logic signed [ZW-1:0]     cord_angle;

    logic signed [AW-1:0] mul_a;
    logic [16:0]          mul_b;
    logic signed [PW-1:0] prod;

    logic [imu_cf_pkg::MAG_W-1:0] mag;
    logic [16:0]          w_eff, w_rem;
    logic signed [PW-1:0] gyro_rnd, blend_sum;
    logic signed [XW-1:0] gyro_inc, blend_q, pitch_ext, roll_ext;

    imu_cf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cord_req),
        .stat    (cord_stat),
        .angle   (cord_angle)
    );

    imu_cf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign mag = {1'b0, imu_cf_pkg::abs16(ax_reg)} + {1'b0, imu_cf_pkg::abs16(ay_reg)}
               + {1'b0, imu_cf_pkg::abs16(az_reg)};
    assign w_eff     = weight_reg[16] ? imu_cf_pkg::WEIGHT_ONE : weight_reg;
    assign w_rem     = imu_cf_pkg::WEIGHT_ONE - w_eff;
    assign gyro_rnd  = prod + PW'(128);
    assign gyro_inc  = gyro_rnd[XW+7:8];
    assign blend_sum = sum_reg + prod;
    assign blend_q   = blend_sum[XW+15:16];
    assign pitch_ext = {{(XW-AW){pitch_reg[AW-1]}}, pitch_reg};
    assign roll_ext  = {{(XW-AW){roll_reg[AW-1]}}, roll_reg};

    always_comb begin
        state_next       = state_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        az_next          = az_reg;
        gx_next          = gx_reg;
        gy_next          = gy_reg;
        trusted_next     = trusted_reg;
        pitch_next       = pitch_reg;
        roll_next        = roll_reg;
        accp_next        = accp_reg;
        sum_next         = sum_reg;
        mag_low_next     = mag_low_reg;
        mag_high_next    = mag_high_reg;
        gain_next        = gain_reg;
        weight_next      = weight_reg;
        m_tvalid_next    = m_tvalid_reg;
        out_pitch_next   = out_pitch_reg;
        out_roll_next    = out_roll_reg;
        out_trusted_next = out_trusted_reg;
        mul_a            = '0;
        mul_b            = '0;
        cord_req.start   = 1'b0;
        cord_req.y       = ax_reg;
        cord_req.x       = az_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                imu_cf_pkg::REG_MAG_LOW:  mag_low_next  = cfg_wr_data;
                imu_cf_pkg::REG_MAG_HIGH: mag_high_next = cfg_wr_data;
                imu_cf_pkg::REG_GAIN:     gain_next     = cfg_wr_data[15:0];
                imu_cf_pkg::REG_WEIGHT:   weight_next   = cfg_wr_data;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ax_next        = s_tdata[15:0];
                    ay_next        = s_tdata[31:16];
                    az_next        = s_tdata[47:32];
                    gx_next        = s_tdata[63:48];
                    gy_next        = s_tdata[79:64];
                    cord_req.start = 1'b1;
                    cord_req.y     = s_tdata[31:16];
                    cord_req.x     = s_tdata[47:32];
                    state_next     = ST_G1;
                end
            end
            ST_G1: begin
                mul_a        = {{(AW-16){gx_reg[15]}}, gx_reg};
                mul_b        = {1'b0, gain_reg};
                trusted_next = (mag > {1'b0, mag_low_reg}) && (mag < {1'b0, mag_high_reg});
                state_next   = ST_G2;
            end
            ST_G2: begin
                mul_a      = {{(AW-16){gy_reg[15]}}, gy_reg};
                mul_b      = {1'b0, gain_reg};
                pitch_next = imu_cf_pkg::sat32(pitch_ext + gyro_inc);
                state_next = ST_G3;
            end
            ST_G3: begin
                roll_next  = imu_cf_pkg::sat32(roll_ext - gyro_inc);
                state_next = trusted_reg ? ST_WP : ST_OUT;
            end
            ST_WP: begin
                if (cord_stat.valid) begin
                    accp_next      = cord_angle;
                    cord_req.start = 1'b1;
                    state_next     = ST_B1;
                end
            end
            ST_B1: begin
                mul_a      = pitch_reg;
                mul_b      = w_eff;
                state_next = ST_B2;
            end
            ST_B2: begin
                mul_a      = {{(AW-ZW){accp_reg[ZW-1]}}, accp_reg};
                mul_b      = w_rem;
                sum_next   = prod + PW'(32768);
                state_next = ST_B3;
            end
            ST_B3: begin
                pitch_next = imu_cf_pkg::sat32(blend_q);
                state_next = ST_WR;
            end
            ST_WR: begin
                if (cord_stat.valid) begin
                    state_next = ST_C1;
                end
            end
            ST_C1: begin
                mul_a      = roll_reg;
                mul_b      = w_eff;
                state_next = ST_C2;
            end
            ST_C2: begin
                mul_a      = {{(AW-ZW){cord_angle[ZW-1]}}, cord_angle};
                mul_b      = w_rem;
                sum_next   = prod + PW'(32768);
                state_next = ST_C3;
            end
            ST_C3: begin
                roll_next  = imu_cf_pkg::sat32(blend_q);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_pitch_next   = pitch_reg;
                    out_roll_next    = roll_reg;
                    out_trusted_next = trusted_reg;
                    m_tvalid_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pitch_reg    <= '0;
            roll_reg     <= '0;
            mag_low_reg  <= 17'd8192;
            mag_high_reg <= 17'd32768;
            gain_reg     <= 16'd10230;
            weight_reg   <= 17'd64225;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pitch_reg    <= pitch_next;
            roll_reg     <= roll_next;
            mag_low_reg  <= mag_low_next;
            mag_high_reg <= mag_high_next;
            gain_reg     <= gain_next;
            weight_reg   <= weight_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ax_reg          <= ax_next;
        ay_reg          <= ay_next;
        az_reg          <= az_next;
        gx_reg          <= gx_next;
        gy_reg          <= gy_next;
        trusted_reg     <= trusted_next;
        accp_reg        <= accp_next;
        sum_reg         <= sum_next;
        out_pitch_reg   <= out_pitch_next;
        out_roll_reg    <= out_roll_next;
        out_trusted_reg <= out_trusted_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_roll_reg, out_pitch_reg};
    assign m_tuser  = out_trusted_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_G1))
        else $error("accepted beat did not start processing");

    a_blend_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B1) |-> (trusted_reg && cord_stat.busy && !cord_stat.valid))
        else $error("pitch blend without roll CORDIC running");

    a_untrusted_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_G3 && !trusted_reg) |=> (state_reg == ST_OUT))
        else $error("untrusted sample entered CORDIC path");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output beat raised outside output state");
`endif

endmodule

// ===== verif/tb_imu_complementary_filter.sv =====
// Self-checking testbench: predicts pitch/roll per sample and compares every output beat.
module tb_imu_complementary_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;

    localparam longint ATAN_Q16 [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // first field in the highest bits
    typedef struct packed {
        logic signed [15:0] gy;
        logic signed [15:0] gx;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } imu_sample_t;

    typedef struct {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic               trusted;
    } attitude_t;

    class attitude_model;
        longint             mag_low;
        longint             mag_high;
        longint             gain;
        longint             weight;
        logic signed [31:0] pitch_q;
        logic signed [31:0] roll_q;
        attitude_t          pending[$];
        int                 mismatches;

        function new();
            mag_low    = 8192;
            mag_high   = 32768;
            gain       = 10230;
            weight     = 64225;
            pitch_q    = '0;
            roll_q     = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [imu_cf_pkg::CFG_ADDR_W-1:0] addr,
                              logic [imu_cf_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                imu_cf_pkg::REG_MAG_LOW:  mag_low  = longint'(data);
                imu_cf_pkg::REG_MAG_HIGH: mag_high = longint'(data);
                imu_cf_pkg::REG_GAIN:     gain     = longint'(data[15:0]);
                imu_cf_pkg::REG_WEIGHT:   weight   = longint'(data);
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clip_q16(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        // vectoring CORDIC, result in Q16.16 degrees
        function longint atan2_deg(longint y, longint x);
            longint z;
            longint t;
            longint dx;
            longint dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 16384;
            y = y * 16384;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 90 * 65536;
                end else begin
                    t = x; x = -y; y = t; z = -90 * 65536;
                end
            end
            for (int i = 0; i < imu_cf_pkg::CORDIC_STEPS && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx; y = y - dy; z = z + ATAN_Q16[i];
                end else begin
                    x = x - dx; y = y + dy; z = z - ATAN_Q16[i];
                end
            end
            return z;
        endfunction

        function logic signed [31:0] mix(logic signed [31:0] ang, longint acc, longint w);
            longint s;
            s = longint'(ang) * w + acc * (65536 - w) + 32768;
            return clip_q16(s >>> 16);
        endfunction

        function void note_sample(imu_sample_t smp);
            longint    ax, ay, az, gx, gy, mag, w;
            attitude_t exp_att;
            ax = longint'(smp.ax);
            ay = longint'(smp.ay);
            az = longint'(smp.az);
            gx = longint'(smp.gx);
            gy = longint'(smp.gy);
            pitch_q = clip_q16(longint'(pitch_q) + ((gx * gain + 128) >>> 8));
            roll_q  = clip_q16(longint'(roll_q) - ((gy * gain + 128) >>> 8));
            mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
            exp_att.trusted = (mag > mag_low) && (mag < mag_high);
            if (exp_att.trusted) begin
                w = (weight > 65536) ? 65536 : weight;
                pitch_q = mix(pitch_q, atan2_deg(ay, az), w);
                roll_q  = mix(roll_q, atan2_deg(ax, az), w);
            end
            exp_att.pitch = pitch_q;
            exp_att.roll  = roll_q;
            pending.push_back(exp_att);
        endfunction

        function void check_result(logic [63:0] tdata, logic tuser);
            attitude_t exp_att;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected beat: pitch=%0d roll=%0d trusted=%0b",
                             $realtime, $signed(tdata[31:0]), $signed(tdata[63:32]), tuser);
                return;
            end
            exp_att = pending.pop_front();
            if (tdata[31:0] !== exp_att.pitch || tdata[63:32] !== exp_att.roll ||
                tuser !== exp_att.trusted) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] exp pitch=%0d roll=%0d trusted=%0b, ",
                              "got pitch=%0d roll=%0d trusted=%0b"},
                             $realtime, exp_att.pitch, exp_att.roll, exp_att.trusted,
                             $signed(tdata[31:0]), $signed(tdata[63:32]), tuser);
            end
        endfunction
    endclass

    logic                                  aclk        = 1'b0;
    logic                                  aresetn     = 1'b0;
    logic                                  s_tvalid    = 1'b0;
    logic                                  s_tready;
    logic [79:0]                           s_tdata     = '0;
    logic                                  m_tvalid;
    logic                                  m_tready    = 1'b0;
    logic [63:0]                           m_tdata;
    logic                                  m_tuser;
    logic                                  cfg_wr_en   = 1'b0;
    logic [imu_cf_pkg::CFG_ADDR_W-1:0]     cfg_addr    = '0;
    logic [imu_cf_pkg::CFG_DATA_W-1:0]     cfg_wr_data = '0;

    int            sender_idle_pct = 0;
    int            recv_stall_pct  = 0;
    int            idle_cycles     = 0;
    attitude_model model           = new();

    imu_complementary_filter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            model.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // longest quiet stretch: one trusted sample, receiver stalls, drain pause, config writes
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_sample(input imu_sample_t smp);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        model.note_sample(smp);
    endtask

    task automatic send_fields(input int ax, input int ay, input int az, input int gx,
                               input int gy);
        imu_sample_t smp;
        smp.ax = 16'(ax);
        smp.ay = 16'(ay);
        smp.az = 16'(az);
        smp.gx = 16'(gx);
        smp.gy = 16'(gy);
        send_sample(smp);
    endtask

    task automatic cfg_write(input logic [imu_cf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [imu_cf_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        model.set_reg(addr, data);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_settings(input int lo, input int hi, input int gain, input int wt);
        drain();
        cfg_write(imu_cf_pkg::REG_MAG_LOW, imu_cf_pkg::CFG_DATA_W'(lo));
        cfg_write(imu_cf_pkg::REG_MAG_HIGH, imu_cf_pkg::CFG_DATA_W'(hi));
        cfg_write(imu_cf_pkg::REG_GAIN, imu_cf_pkg::CFG_DATA_W'(gain));
        cfg_write(imu_cf_pkg::REG_WEIGHT, imu_cf_pkg::CFG_DATA_W'(wt));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] corner_value();
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'sh0001;
        endcase
    endfunction

    // style 0: mixed accel spread; 1/2: gyro pinned near +/- full scale
    function automatic imu_sample_t make_sample(int style);
        imu_sample_t smp;
        int          lim;
        int          pick;
        smp.ax = 16'($urandom);
        smp.ay = 16'($urandom);
        smp.az = 16'($urandom);
        smp.gx = 16'($urandom);
        smp.gy = 16'($urandom);
        if (style != 0) begin
            smp.gx = 16'($urandom_range(32767, 30000));
            smp.gy = 16'($urandom_range(32767, 30000));
            if (style == 2) begin
                smp.gx = -smp.gx;
                smp.gy = -smp.gy;
            end
            return smp;
        end
        case ($urandom_range(2))
            0: lim = 3000;
            1: lim = 12000;
            default: lim = 30000;
        endcase
        pick = $urandom_range(9);
        if (pick < 7) begin
            smp.ax = 16'(int'($urandom_range(2 * lim)) - lim);
            smp.ay = 16'(int'($urandom_range(2 * lim)) - lim);
            smp.az = 16'(int'($urandom_range(2 * lim)) - lim);
        end
        if (pick == 5) begin
            smp.ax = corner_value();
            smp.ay = corner_value();
            smp.az = corner_value();
            smp.gx = corner_value();
            smp.gy = corner_value();
        end else if (pick == 6) begin
            if ($urandom_range(1)) smp.ax = '0;
            if ($urandom_range(1)) smp.ay = '0;
            if ($urandom_range(1)) smp.az = '0;
        end
        if ($urandom_range(3) == 0) begin
            smp.gx = 16'(int'($urandom_range(200)) - 100);
            smp.gy = 16'(int'($urandom_range(200)) - 100);
        end
        return smp;
    endfunction

    task automatic run_random(input int count, input int style);
        repeat (count) send_sample(make_sample(style));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings
        send_fields(0, 0, 0, 0, 0);
        send_fields(32767, 32767, 32767, 32767, -32768);
        send_fields(-32768, -32768, -32768, -32768, 32767);
        send_fields(0, 0, 16384, 100, -100);
        send_fields(0, 0, -16384, 0, 0);
        send_fields(16384, 0, 0, 0, 0);
        send_fields(0, -16384, 0, 0, 0);
        send_fields(5000, -6000, -7000, 1, 1);
        send_fields(-3000, 6000, -7000, -1, -1);
        send_fields(8192, 0, 0, 0, 0);
        send_fields(16384, 0, 16384, 0, 0);
        send_fields(8193, 0, 0, 0, 0);
        send_fields(0, -16383, -16384, 0, 0);

        // widest window, max gain, weight above one
        apply_settings(0, 98304, 65535, 131071);
        send_fields(100, 0, 0, 32767, -32768);
        send_fields(0, 0, -30000, 0, 0);
        send_fields(0, 0, 0, 0, 0);
        send_fields(-32768, -32768, -32768, 0, 0);
        send_fields(-32768, -32767, -32768, 0, 0);

        // inverted window
        apply_settings(98304, 98304, 1, 0);
        send_fields(10000, 10000, 10000, 32767, 32767);
        send_fields(-1, -1, -1, -32768, -32768);
        apply_settings(20000, 10000, 10230, 0);
        send_fields(5000, 5000, 5000, 0, 0);

        apply_settings(8192, 32768, 10230, 64225);
        sender_idle_pct = 48;
        recv_stall_pct  = 0;
        run_random(60, 0);

        apply_settings(0, 98304, 0, 0);
        sender_idle_pct = 0;
        recv_stall_pct  = 48;
        run_random(60, 0);

        // gyro only at full gain: pitch pinned high, roll pinned low, then back off
        apply_settings(98304, 0, 65535, 65536);
        sender_idle_pct = 32;
        recv_stall_pct  = 32;
        run_random(300, 1);
        run_random(40, 2);

        apply_settings(1, 65536, int'($urandom_range(65535)), 131071);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_random(60, 0);

        apply_settings(int'($urandom_range(98304)), int'($urandom_range(98304)),
                       int'($urandom_range(65535)), int'($urandom_range(65536)));
        sender_idle_pct = 32;
        recv_stall_pct  = 32;
        run_random(60, 0);

        s_tvalid <= 1'b0;
        while (model.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (model.mismatches == 0 && model.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
